/* design/lgfd_pkg.sv */
// Package: constants, codes and the elaboration-time gamma table for the LED dimmer.
`timescale 1ns / 1ps
`default_nettype none
package lgfd_pkg;

  localparam int CHANNELS     = 6;
  localparam int GAMMA_TENTHS = 22;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int RAMP_W   = 17;
  localparam int STEP_W   = 17;
  localparam int MUL_W    = 17;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int GAMMA_W  = 10;
  localparam int LEVEL_W  = 8;
  localparam int ELAPSED_W = 16;

  localparam logic [RAMP_W-1:0] RAMP_FULL = RAMP_W'(65536);

  // Item kinds
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_ARM  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Register select (address bit 2)
  localparam logic REG_RAMP_UP = 1'b0;
  localparam logic REG_FADE    = 1'b1;

  localparam logic [STEP_W-1:0] RAMP_UP_RESET = STEP_W'(131);
  localparam logic [STEP_W-1:0] FADE_RESET    = STEP_W'(66);

  typedef logic [GAMMA_W-1:0] gamma_rom_t [256];

  // gamma[i] is the largest v in 0..1023 with
  // i^G * 2046^10 >= (2v-1)^10 * 255^G, G = GAMMA_TENTHS (round half up).
  function automatic gamma_rom_t build_gamma();
    logic [447:0] base_pow;
    logic [447:0] lhs;
    logic [447:0] rhs;
    int           lo;
    int           hi;
    int           mid;
    gamma_rom_t   rom;
    base_pow = 448'd1;
    for (int k = 0; k < GAMMA_TENTHS; k++) begin
      base_pow = base_pow * 448'd255;
    end
    rom[0] = '0;
    for (int i = 1; i < 256; i++) begin
      lhs = 448'd1;
      for (int k = 0; k < GAMMA_TENTHS; k++) begin
        lhs = lhs * 448'(i);
      end
      for (int k = 0; k < 10; k++) begin
        lhs = lhs * 448'd2046;
      end
      lo = 0;
      hi = 1023;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        rhs = base_pow;
        for (int k = 0; k < 10; k++) begin
          rhs = rhs * 448'(2 * mid - 1);
        end
        if (lhs >= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      rom[i] = GAMMA_W'(lo);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage
`default_nettype wire

/* design/lgfd_in_if.sv */
// Interface: input item channel of the LED dimmer.
`timescale 1ns / 1ps
`default_nettype none
interface lgfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  channel;
  logic [7:0]  level;
  logic        arm;
  logic [15:0] elapsed_ms;

  modport source (output valid, kind, channel, level, arm, elapsed_ms, input ready);
  modport sink   (input valid, kind, channel, level, arm, elapsed_ms, output ready);
endinterface
`default_nettype wire

/* design/lgfd_out_if.sv */
// Interface: duty result channel of the LED dimmer.
`timescale 1ns / 1ps
`default_nettype none
interface lgfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_channel;
  logic [9:0] duty;
  logic       last;
  logic       is_armed;
  logic       fully_on;
  logic       fully_off;

  modport source (output valid, out_channel, duty, last, is_armed, fully_on, fully_off,
                  input ready);
  modport sink   (input valid, out_channel, duty, last, is_armed, fully_on, fully_off,
                  output ready);
endinterface
`default_nettype wire

/* design/led_gamma_fade_dimmer_unit.sv */
// Top level: six-channel gamma-corrected LED dimmer with a fade ramp.
//
//  channel   direction  handshake               payload
//  in_i      in         valid/ready             kind, channel, level, arm, elapsed_ms
//  out_o     out        valid/ready             out_channel, duty, last, is_armed,
//                                               fully_on, fully_off
//  apb       in         psel/penable/pready     paddr, pwdata, prdata (2 step regs)
//
// Set and arm items are applied as they are accepted. A tick runs one multiply
// and one saturating update for the ramp, then a multiply and an emit per channel,
// the multiplies all on the single shared 17x17 multiplier. A stalled sink holds
// the emit step.
// Reset (async, active low) clears levels, armed flag, ramp and loads step defaults.
// The result register lets the sequencer work on the next channel while a
// transfer waits.
`timescale 1ns / 1ps
`default_nettype none
module led_gamma_fade_dimmer_unit
  import lgfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  lgfd_in_if.sink          in_i,
  lgfd_out_if.source       out_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RAMP_MUL = 3'd1;
  localparam logic [2:0] S_RAMP_UPD = 3'd2;
  localparam logic [2:0] S_CH_MUL   = 3'd3;
  localparam logic [2:0] S_CH_OUT   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [STEP_W-1:0]   ramp_up_q, fade_q;
  logic [RAMP_W-1:0]   ramp_q, ramp_d;
  logic                armed_q;
  logic [LEVEL_W-1:0]  levels_q [CHANNELS];
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [ELAPSED_W-1:0] elapsed_q;

  // result register
  logic                out_valid_q;
  logic [2:0]          out_ch_q;
  logic [GAMMA_W-1:0]  out_duty_q;
  logic                out_last_q, out_armed_q, out_on_q, out_off_q;

  logic                in_fire, cfg_wr, out_free, ch_last, emit;
  logic                mul_en;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W:0]     ramp_sum;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_RAMP_UP: prdata = 32'(ramp_up_q);
      REG_FADE:    prdata = 32'(fade_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_up_q <= RAMP_UP_RESET;
      fade_q    <= FADE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RAMP_UP) begin
        ramp_up_q <= pwdata[STEP_W-1:0];
      end else begin
        fade_q <= pwdata[STEP_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign ch_last    = (ch_q == CH_IDX_W'(CHANNELS - 1));
  assign emit       = (state_q == S_CH_OUT) && out_free;

  // Shared multiplier operands: elapsed*step for the ramp, gamma*ramp per channel.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_RAMP_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(elapsed_q);
        mul_b  = armed_q ? ramp_up_q : fade_q;
      end
      S_CH_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(GAMMA_ROM[levels_q[ch_q]]);
        mul_b  = ramp_q;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  lgfd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Saturating ramp update from the registered product.
  assign ramp_sum = (PROD_W + 1)'(mul_p) + (PROD_W + 1)'(ramp_q);

  always_comb begin
    ramp_d = ramp_q;
    if (state_q == S_RAMP_UPD) begin
      if (armed_q) begin
        ramp_d = (ramp_sum >= (PROD_W + 1)'(RAMP_FULL)) ? RAMP_FULL
                                                        : ramp_sum[RAMP_W-1:0];
      end else begin
        ramp_d = (mul_p >= PROD_W'(ramp_q)) ? '0 : (ramp_q - mul_p[RAMP_W-1:0]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_i.kind == KIND_TICK) begin
          state_d = S_RAMP_MUL;
        end
      end
      S_RAMP_MUL: state_d = S_RAMP_UPD;
      S_RAMP_UPD: begin
        state_d = S_CH_MUL;
        ch_d    = '0;
      end
      S_CH_MUL:   state_d = S_CH_OUT;
      S_CH_OUT: begin
        if (out_free) begin
          if (ch_last) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_CH_MUL;
            ch_d    = ch_q + CH_IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      ramp_q  <= '0;
      armed_q <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        levels_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      ramp_q  <= ramp_d;
      if (in_fire) begin
        case (in_i.kind)
          KIND_SET: begin
            // indices past the last channel are dropped
            if ({1'b0, in_i.channel} < 4'(CHANNELS)) begin
              levels_q[in_i.channel[CH_IDX_W-1:0]] <= in_i.level;
            end
          end
          KIND_ARM: armed_q <= in_i.arm;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elapsed_q <= in_i.elapsed_ms;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_ch_q    <= 3'(ch_q);
      out_duty_q  <= mul_p[16 +: GAMMA_W];
      out_last_q  <= ch_last;
      out_armed_q <= armed_q;
      out_on_q    <= (ramp_q >= RAMP_FULL);
      out_off_q   <= (ramp_q == '0);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.duty        = out_duty_q;
  assign out_o.last        = out_last_q;
  assign out_o.is_armed    = out_armed_q;
  assign out_o.fully_on    = out_on_q;
  assign out_o.fully_off   = out_off_q;

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind == KIND_TICK |=> state_q == S_RAMP_MUL)
    else $error("tick accepted but ramp multiply not started");

  a_ramp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_q <= RAMP_FULL)
    else $error("ramp above full scale");

  a_fade_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RAMP_UPD && !armed_q |=> ramp_q <= $past(ramp_q))
    else $error("ramp rose while disarmed");

  a_ch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CH_OUT |-> ch_q <= CH_IDX_W'(CHANNELS - 1))
    else $error("channel counter out of range");
`endif

endmodule
`default_nettype wire

/* design/lgfd_mul.sv */
// Shared registered multiplier used for both the ramp step and the channel duties.
`timescale 1ns / 1ps
`default_nettype none
module lgfd_mul
  import lgfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [MUL_W-1:0]  a_i,
  input  wire logic [MUL_W-1:0]  b_i,
  output logic      [PROD_W-1:0] p_o
);

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire
